// ----- rtl/lcdns_pkg.sv -----
// Shared types and constants for the LCD expander nibble sequencer.
package lcdns_pkg;

  localparam logic [2:0] CMD_INSTR     = 3'd0;
  localparam logic [2:0] CMD_DATA      = 3'd1;
  localparam logic [2:0] CMD_DISP_ADDR = 3'd2;
  localparam logic [2:0] CMD_GLYPH     = 3'd3;
  localparam logic [2:0] CMD_POSITION  = 3'd4;
  localparam logic [2:0] CMD_LIGHT_ON  = 3'd5;
  localparam logic [2:0] CMD_LIGHT_OFF = 3'd6;
  localparam logic [2:0] CMD_TOGGLE    = 3'd7;

  localparam logic [0:0] REG_BUS_ADDR = 1'b0;
  localparam logic [0:0] REG_RS_MASK  = 1'b1;

  localparam logic [7:0] ENABLE_BIT   = 8'h04;
  localparam logic [7:0] LIGHT_BIT    = 8'h08;
  localparam logic [7:0] GLYPH_FLAG   = 8'h40;
  localparam logic [7:0] DISPLAY_FLAG = 8'h80;
  localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;

  localparam logic [7:0] LINE1_BASE = 8'h00;
  localparam logic [7:0] LINE2_BASE = 8'h40;
  localparam logic [7:0] LINE3_BASE = 8'h14;
  localparam logic [7:0] LINE4_BASE = 8'h54;

  localparam logic [6:0] BUS_ADDR_RESET = 7'd39;
  localparam logic [7:0] RS_MASK_RESET  = 8'd1;

  localparam logic [2:0] LAST_STEP = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
    logic [2:0] line_number;
    logic [7:0] column;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic [6:0] bus_address;
    logic       last;
  } out_beat_t;

  // One decoded request: nibble base bytes, or a single backlight byte in hi.
  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
    logic       single;
  } job_t;

endpackage

// ----- rtl/lcdns_decode.sv -----
// Request decode stage: backlight state and the job register.
module lcdns_decode
  import lcdns_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_beat_t in_beat,
  output logic     in_stall,
  input  logic [7:0] rs_mask,
  input  logic     job_take,
  output logic     job_valid,
  output job_t     job
);

  logic       job_valid_r, job_valid_nxt;
  job_t       job_r, job_nxt;
  logic       light_r, light_nxt;
  logic       accept;
  logic       has_bytes;
  logic [7:0] light_byte;
  logic [7:0] extra;
  logic [7:0] addr;
  logic [7:0] line_base;
  logic       line_ok;
  logic [7:0] v;

  assign in_stall = job_valid_r && !job_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    line_ok = 1'b1;
    case (in_beat.line_number)
      3'd1: line_base = LINE1_BASE;
      3'd2: line_base = LINE2_BASE;
      3'd3: line_base = LINE3_BASE;
      3'd4: line_base = LINE4_BASE;
      default: begin
        line_base = LINE1_BASE;
        line_ok   = 1'b0;
      end
    endcase
  end

  // base + column - 1, wraps at 8 bits
  assign addr       = line_base + in_beat.column + 8'hFF;
  assign light_byte = light_r ? LIGHT_BIT : 8'h00;

  always_comb begin
    light_nxt = light_r;
    has_bytes = 1'b1;
    extra     = light_byte;
    v         = in_beat.value;
    job_nxt   = job_r;
    case (in_beat.command)
      CMD_INSTR:     v = in_beat.value;
      CMD_DATA:      extra = light_byte | rs_mask;
      CMD_DISP_ADDR: v = in_beat.value | DISPLAY_FLAG;
      CMD_GLYPH:     v = in_beat.value | GLYPH_FLAG;
      CMD_POSITION: begin
        v         = addr | DISPLAY_FLAG;
        has_bytes = line_ok;
      end
      CMD_LIGHT_ON:  light_nxt = 1'b1;
      CMD_LIGHT_OFF: light_nxt = 1'b0;
      CMD_TOGGLE:    light_nxt = !light_r;
      default:       light_nxt = light_r;
    endcase
    if (in_beat.command == CMD_LIGHT_ON || in_beat.command == CMD_LIGHT_OFF ||
        in_beat.command == CMD_TOGGLE) begin
      job_nxt.hi     = light_nxt ? LIGHT_BIT : 8'h00;
      job_nxt.lo     = 8'h00;
      job_nxt.single = 1'b1;
    end else begin
      job_nxt.hi     = (v & HIGH_NIBBLE) + extra;
      job_nxt.lo     = {v[3:0], 4'h0} + extra;
      job_nxt.single = 1'b0;
    end
  end

  assign job_valid_nxt = accept ? has_bytes : (job_valid_r && !job_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      light_r     <= 1'b1;
    end else begin
      job_valid_r <= job_valid_nxt;
      if (accept) begin
        light_r <= light_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

// ----- rtl/lcdns_emit.sv -----
// Byte sequencer: walks a job through its steps into the output register.
module lcdns_emit
  import lcdns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  input  logic [6:0] bus_addr,
  output logic       job_take,
  input  logic       out_stall,
  output logic       out_valid,
  output out_beat_t  out_beat
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_beat_r, out_beat_nxt;
  logic       advance;
  logic       load;
  logic       fin;
  logic [7:0] byte_sel;

  assign advance  = !out_valid_r || !out_stall;
  assign load     = job_valid && advance;
  assign fin      = job.single || (step_r == LAST_STEP);
  assign job_take = load && fin;

  always_comb begin
    case (step_r)
      3'd0:    byte_sel = job.hi;
      3'd1:    byte_sel = job.hi + ENABLE_BIT;
      3'd2:    byte_sel = job.hi;
      3'd3:    byte_sel = job.lo;
      3'd4:    byte_sel = job.lo + ENABLE_BIT;
      3'd5:    byte_sel = job.lo;
      default: byte_sel = job.lo;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    if (load) begin
      step_nxt                   = fin ? 3'd0 : step_r + 3'd1;
      out_valid_nxt              = 1'b1;
      out_beat_nxt.expander_byte = job.single ? job.hi : byte_sel;
      out_beat_nxt.bus_address   = bus_addr;
      out_beat_nxt.last          = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ----- rtl/lcd_i2c_nibble_sequencer_core.sv -----
// Top level of the LCD expander nibble sequencer.
//
// Usage:
//   in_*  : one request beat (command, value, line, column), valid/stall.
//   out_* : expander byte beats (byte, I2C address, last), valid/stall.
//   cfg_* : register writes; index 0 = bus address, 1 = register-select
//           mask. cfg_ready is always high; write only while idle.
// Instruction, data, address, glyph and position requests give six
// beats each (high nibble, with enable, without; then low nibble alike);
// backlight requests one; a position request with a bad line gives none.
// Latency: a taken request is registered in the decode stage's job
// register, and its first result beat then in the output register.
// Throughput: one output beat per cycle while out_stall is low, set by
// the output register's step counter. The next request is taken in the
// cycle the final beat of the current one loads, so there is no gap
// between jobs.
// Out stall: the output register holds; the sequencer freezes and, once
// its job buffer is full, in_stall rises.
// Reset: backlight on, bus address 39, select mask 1, no beats pending.
module lcd_i2c_nibble_sequencer_core
  import lcdns_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] bus_addr_r;
  logic [7:0] rs_mask_r;
  logic       job_valid;
  logic       job_take;
  job_t       job;

  // Config registers: always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_addr_r <= BUS_ADDR_RESET;
      rs_mask_r  <= RS_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUS_ADDR: bus_addr_r <= cfg_data[6:0];
        REG_RS_MASK:  rs_mask_r  <= cfg_data;
        default:      rs_mask_r  <= rs_mask_r;
      endcase
    end
  end

  // Decode stage: builds nibble base bytes, owns the backlight bit.
  lcdns_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .rs_mask   (rs_mask_r),
    .job_take  (job_take),
    .job_valid (job_valid),
    .job       (job)
  );

  // Emit stage: one expander byte per cycle into the output register while out_stall is low.
  lcdns_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .bus_addr  (bus_addr_r),
    .job_take  (job_take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

// ----- tb/lcd_i2c_nibble_sequencer_core_test.sv -----
// Self-checking testbench for the LCD expander nibble sequencer core.
module lcd_i2c_nibble_sequencer_core_test
  import lcdns_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expander byte predictor and in-order store of the beats it expects.
  class expander_scoreboard;
    out_beat_t  byte_queue[$];
    logic [6:0] bus_addr;
    logic [7:0] rs_mask;
    logic       light_on;
    int         errors;
    int         requests;
    int         beats_seen;

    function new();
      bus_addr   = BUS_ADDR_RESET;
      rs_mask    = RS_MASK_RESET;
      light_on   = 1'b1;
      errors     = 0;
      requests   = 0;
      beats_seen = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [7:0] data);
      if (idx == REG_BUS_ADDR) begin
        bus_addr = data[6:0];
      end else begin
        rs_mask = data;
      end
    endfunction

    function int pending();
      return byte_queue.size();
    endfunction

    function void push_byte(logic [7:0] b, logic fin);
      out_beat_t e;
      e.expander_byte = b;
      e.bus_address   = bus_addr;
      e.last          = fin;
      byte_queue.push_back(e);
    endfunction

    // High nibble then low nibble, each as base / base+enable / base.
    // The extra bits are added, not ORed, so overlaps carry.
    function void push_nibbles(logic [7:0] v, logic [7:0] extra);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = (v & HIGH_NIBBLE) + extra;
      lo = {v[3:0], 4'h0} + extra;
      push_byte(hi, 1'b0);
      push_byte(hi + ENABLE_BIT, 1'b0);
      push_byte(hi, 1'b0);
      push_byte(lo, 1'b0);
      push_byte(lo + ENABLE_BIT, 1'b0);
      push_byte(lo, 1'b1);
    endfunction

    // Returns the number of beats the request is expected to cause.
    function int note_request(in_beat_t b);
      logic [7:0] light;
      logic [7:0] base;
      logic [7:0] ddram;
      int         before_cnt;
      before_cnt = byte_queue.size();
      light = light_on ? LIGHT_BIT : 8'h00;
      requests++;
      case (b.command)
        CMD_INSTR:     push_nibbles(b.value, light);
        CMD_DATA:      push_nibbles(b.value, light | rs_mask);
        CMD_DISP_ADDR: push_nibbles(b.value | DISPLAY_FLAG, light);
        CMD_GLYPH:     push_nibbles(b.value | GLYPH_FLAG, light);
        CMD_POSITION: begin
          case (b.line_number)
            3'd1:    base = LINE1_BASE;
            3'd2:    base = LINE2_BASE;
            3'd3:    base = LINE3_BASE;
            3'd4:    base = LINE4_BASE;
            default: base = 8'h00;
          endcase
          // bad line: nothing at all
          if (b.line_number >= 3'd1 && b.line_number <= 3'd4) begin
            ddram = base + b.column - 8'd1;
            push_nibbles(ddram | DISPLAY_FLAG, light);
          end
        end
        default: begin
          if (b.command == CMD_LIGHT_ON) begin
            light_on = 1'b1;
          end else if (b.command == CMD_LIGHT_OFF) begin
            light_on = 1'b0;
          end else begin
            light_on = !light_on;
          end
          push_byte(light_on ? LIGHT_BIT : 8'h00, 1'b1);
        end
      endcase
      return byte_queue.size() - before_cnt;
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t e;
      beats_seen++;
      if (byte_queue.size() == 0) begin
        $error("unexpected beat: byte %02h addr %02h last %0b",
               got.expander_byte, got.bus_address, got.last);
        errors++;
        return;
      end
      e = byte_queue.pop_front();
      if (got.expander_byte !== e.expander_byte) begin
        $error("expander_byte: expected %02h, actual %02h", e.expander_byte, got.expander_byte);
        errors++;
      end
      if (got.bus_address !== e.bus_address) begin
        $error("bus_address: expected %02h, actual %02h", e.bus_address, got.bus_address);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_beat;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_beat;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  expander_scoreboard sb;
  logic no_idle;      // when set, neither side inserts gaps or stalls
  int   setting_cnt;

  lcd_i2c_nibble_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit: covers ~400 requests of up to 6 beats each, every beat behind
  // its own random stall run, plus request gaps, with a wide margin.
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  function int pick_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Result side: every beat gets its own random stall run ahead of it.
  // Stall is driven on the falling edge, beats sampled on the rising edge.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = pick_wait();
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Accepted result beats go straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_beat(out_beat);
    end
  end

  // One request beat: optional gap with valid low, then present and hold
  // until taken. Valid stays high after acceptance; the next call either
  // replaces the payload or drops valid at the following falling edge.
  task automatic send_request(input in_beat_t b, output int n_beats);
    int gap;
    gap = pick_wait();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    n_beats = sb.note_request(b);
    if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
  endtask

  // Drop valid and let the block drain completely. A bad-line position
  // request yields nothing, so a few extra cycles cover any work in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_beat_t mk_req(logic [2:0] cmd, logic [7:0] val,
                                      logic [2:0] line, logic [7:0] col);
    in_beat_t b;
    b.command     = cmd;
    b.value       = val;
    b.line_number = line;
    b.column      = col;
    return b;
  endfunction

  // Random requests until 'target' of them have produced beats.
  // Position requests mostly use a good line; bad lines still show up.
  task automatic random_phase(input int target);
    in_beat_t b;
    int       done_cnt;
    int       n;
    done_cnt = 0;
    while (done_cnt < target) begin
      b.command = 3'($urandom_range(0, 7));
      b.value   = 8'($urandom_range(0, 255));
      b.column  = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 8) begin
        b.line_number = 3'($urandom_range(1, 4));
      end else begin
        b.line_number = 3'($urandom_range(0, 7));
      end
      send_request(b, n);
      if (n != 0) done_cnt++;
    end
  endtask

  initial begin
    in_beat_t dir_list[$];
    int       n;

    sb          = new();
    no_idle     = 1'b0;
    setting_cnt = 1;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_beat     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_BUS_ADDR;
    cfg_data    = 8'h00;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings: field extremes, every command,
    // column wrap below zero, bad lines, and the backlight state machine
    // feeding into later text writes.
    dir_list.push_back(mk_req(CMD_INSTR,     8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_INSTR,     8'hFF, 3'd7, 8'hFF));
    dir_list.push_back(mk_req(CMD_DATA,      8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_DATA,      8'hFF, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_DATA,      8'h5A, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_DISP_ADDR, 8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_DISP_ADDR, 8'h7F, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_GLYPH,     8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_GLYPH,     8'hFF, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd1, 8'd1));
    dir_list.push_back(mk_req(CMD_POSITION,  8'hFF, 3'd1, 8'd0));   // wraps to 0xFF
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd2, 8'd255));
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd3, 8'd16));
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd4, 8'd20));
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd0, 8'd1));   // bad line
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd5, 8'd1));   // bad line
    dir_list.push_back(mk_req(CMD_POSITION,  8'hFF, 3'd7, 8'd255)); // bad line
    dir_list.push_back(mk_req(CMD_LIGHT_OFF, 8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_DATA,      8'h41, 3'd0, 8'h00));  // no light bit
    dir_list.push_back(mk_req(CMD_TOGGLE,    8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_TOGGLE,    8'hFF, 3'd7, 8'hFF));
    dir_list.push_back(mk_req(CMD_INSTR,     8'h01, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_LIGHT_ON,  8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_LIGHT_ON,  8'h00, 3'd0, 8'h00));
    dir_list.push_back(mk_req(CMD_POSITION,  8'h00, 3'd4, 8'd0));
    foreach (dir_list[i]) send_request(dir_list[i], n);
    wait_idle();

    // Register settings: both extremes, a select mask that overlaps the
    // light bit (carries into bit 4), random, and back to reset values.
    write_reg(REG_BUS_ADDR, 8'h00);
    write_reg(REG_RS_MASK,  8'h00);
    setting_cnt++;
    random_phase(70);
    wait_idle();

    write_reg(REG_BUS_ADDR, 8'hFF);
    write_reg(REG_RS_MASK,  8'hFF);
    setting_cnt++;
    random_phase(70);
    wait_idle();

    write_reg(REG_BUS_ADDR, 8'($urandom_range(0, 255)));
    write_reg(REG_RS_MASK,  LIGHT_BIT);
    setting_cnt++;
    random_phase(70);
    wait_idle();

    write_reg(REG_BUS_ADDR, 8'($urandom_range(0, 255)));
    write_reg(REG_RS_MASK,  8'($urandom_range(0, 255)));
    setting_cnt++;
    random_phase(70);
    wait_idle();

    write_reg(REG_BUS_ADDR, {1'b0, BUS_ADDR_RESET});
    write_reg(REG_RS_MASK,  RS_MASK_RESET);
    setting_cnt++;
    random_phase(70);
    wait_idle();

    // Drained above; give stragglers a little longer before judging.
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected beats never arrived", sb.pending());
      sb.errors++;
    end

    $display("Run covered %0d requests and %0d expander beats over %0d register settings.",
             sb.requests, sb.beats_seen, setting_cnt);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- lcd_i2c_nibble_sequencer_core.f -----
rtl/lcdns_pkg.sv
rtl/lcdns_decode.sv
rtl/lcdns_emit.sv
rtl/lcd_i2c_nibble_sequencer_core.sv
tb/lcd_i2c_nibble_sequencer_core_test.sv
